// ===== hw/rtl/ptb_pkg.sv =====
// Shared types, register indexes and reset constants for the pressure trigger block.
`default_nettype none

package ptb_pkg;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int REQ_DATA_W = 280;
   localparam int RSP_DATA_W = 208;

   localparam logic [15:0] CHECK_INTERVAL_RST = 16'd120;
   localparam logic [31:0] MIN_DISPATCH_RST   = 32'd128;
   localparam logic [31:0] MIN_INSN_RST       = 32'd100000;
   localparam logic [15:0] COOLDOWN_RST       = 16'd300;
   localparam logic [6:0]  BACKOFF_LIMIT_RST  = 7'd64;
   localparam logic [16:0] COUNT_NONE         = 17'h1FFFF;

   typedef enum logic [2:0] {
      REG_TRIGGER_ENABLE = 3'd0,
      REG_CHECK_INTERVAL = 3'd1,
      REG_MIN_DISPATCH   = 3'd2,
      REG_MIN_INSN       = 3'd3,
      REG_COOLDOWN       = 3'd4,
      REG_BACKOFF_LIMIT  = 3'd5,
      REG_SEED_SIGNATURE = 3'd6
   } ptb_reg_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_FINISH = 1'b1
   } ptb_op_type;

   // settings seen by the decision logic, plus a pulse for a write of 1 to the enable
   typedef struct packed {
      logic        trigger_enable;
      logic [15:0] check_interval;
      logic [31:0] min_dispatch_delta;
      logic [31:0] min_insn_delta;
      logic [15:0] cooldown_frames;
      logic [6:0]  backoff_limit;
      logic [63:0] seed_signature;
      logic        enable_set;
   } ptb_cfg_type;

   typedef struct packed {
      ptb_op_type  op;
      logic [63:0] frame_count;
      logic [63:0] dispatch_total;
      logic [63:0] insn_total;
      logic        capture_active;
      logic        loading;
      logic        provider_busy;
      logic [63:0] manifest_signature;
      logic [15:0] registered_count;
   } ptb_item_type;

   typedef struct packed {
      logic        start_capture;
      logic        request_compile;
      logic        futile_skip;
      logic [7:0]  backoff_now;
      logic [31:0] trigger_total;
      logic [31:0] futile_total;
      logic [63:0] dispatch_delta;
      logic [63:0] insn_delta;
   } ptb_result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pressure_trigger_with_backoff.sv =====
// Top level: input register, decision core, result register and config port.
//
// channel | dir | handshake                 | payload
// req     | in  | req_tvalid / req_tready   | req_tuser op, req_tdata frame event fields
// rsp     | out | rsp_tvalid / rsp_tready   | rsp_tdata flags, backoff, totals, deltas
// csr     | in  | psel, penable, pwrite     | 64-bit registers at byte address 8*index
//
// One item per clock while rsp is not stalled; an item passes the input register
// and leaves with its result in the result register.
// The decision core updates all trigger state in the same cycle it writes the result.
// A stalled rsp side holds the result; the input register still takes one more item.
// Synchronous active-high reset clears state; requested count resets to minus one.
`default_nettype none

module pressure_trigger_with_backoff (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   // op
   input  wire                            req_tuser,
   // frame_count, dispatch_total, insn_total, capture_active, loading, provider_busy,
   // manifest_signature, registered_count, zero pad
   input  wire [ptb_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   // start_capture, request_compile, futile_skip, backoff_now, trigger_total,
   // futile_total, dispatch_delta, insn_delta, zero pad
   output logic [ptb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire                            csr_psel,
   input  wire                            csr_penable,
   input  wire                            csr_pwrite,
   input  wire [ptb_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire [ptb_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ptb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import ptb_pkg::*;

   ptb_cfg_type    cfg;
   ptb_item_type   item_ff,  item_in;
   logic           in_vld_ff;
   ptb_result_type res_ff,   res_in;
   logic           out_vld_ff;
   logic           fire;
   logic           take;

   ptb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // item in the input register moves on when the result slot is free or draining
   assign fire       = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || fire;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      item_in.op                 = ptb_op_type'(req_tuser);
      item_in.frame_count        = req_tdata[63:0];
      item_in.dispatch_total     = req_tdata[127:64];
      item_in.insn_total         = req_tdata[191:128];
      item_in.capture_active     = req_tdata[192];
      item_in.loading            = req_tdata[193];
      item_in.provider_busy      = req_tdata[194];
      item_in.manifest_signature = req_tdata[258:195];
      item_in.registered_count   = req_tdata[274:259];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (take) begin
         in_vld_ff <= 1'b1;
      end else if (fire) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   ptb_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (fire),
      .item   (item_ff),
      .result (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (fire) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {5'd0, res_ff.insn_delta, res_ff.dispatch_delta,
                        res_ff.futile_total, res_ff.trigger_total, res_ff.backoff_now,
                        res_ff.futile_skip, res_ff.request_compile, res_ff.start_capture};

endmodule

`default_nettype wire

// ===== hw/rtl/ptb_csr.sv =====
// Configuration register file with APB-style access.
`default_nettype none

module ptb_csr (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           csr_psel,
   input  wire                           csr_penable,
   input  wire                           csr_pwrite,
   input  wire [ptb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire [ptb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ptb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready,
   output ptb_pkg::ptb_cfg_type          cfg
);
   import ptb_pkg::*;

   logic        enable_ff;
   logic [15:0] interval_ff;
   logic [31:0] min_disp_ff;
   logic [31:0] min_insn_ff;
   logic [15:0] cooldown_ff;
   logic [6:0]  limit_ff;
   logic [63:0] seed_ff;
   logic        wr_en;
   ptb_reg_type idx;

   assign idx        = ptb_reg_type'(csr_paddr[5:3]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         interval_ff <= CHECK_INTERVAL_RST;
         min_disp_ff <= MIN_DISPATCH_RST;
         min_insn_ff <= MIN_INSN_RST;
         cooldown_ff <= COOLDOWN_RST;
         limit_ff    <= BACKOFF_LIMIT_RST;
         seed_ff     <= 64'd0;
      end else if (wr_en) begin
         unique case (idx)
            REG_TRIGGER_ENABLE: enable_ff   <= csr_pwdata[0];
            REG_CHECK_INTERVAL: interval_ff <= csr_pwdata[15:0];
            REG_MIN_DISPATCH:   min_disp_ff <= csr_pwdata[31:0];
            REG_MIN_INSN:       min_insn_ff <= csr_pwdata[31:0];
            REG_COOLDOWN:       cooldown_ff <= csr_pwdata[15:0];
            REG_BACKOFF_LIMIT:  limit_ff    <= csr_pwdata[6:0];
            REG_SEED_SIGNATURE: seed_ff     <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_TRIGGER_ENABLE: csr_prdata = {63'd0, enable_ff};
         REG_CHECK_INTERVAL: csr_prdata = {48'd0, interval_ff};
         REG_MIN_DISPATCH:   csr_prdata = {32'd0, min_disp_ff};
         REG_MIN_INSN:       csr_prdata = {32'd0, min_insn_ff};
         REG_COOLDOWN:       csr_prdata = {48'd0, cooldown_ff};
         REG_BACKOFF_LIMIT:  csr_prdata = {57'd0, limit_ff};
         REG_SEED_SIGNATURE: csr_prdata = seed_ff;
         default:            csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.trigger_enable     = enable_ff;
      cfg.check_interval     = interval_ff;
      cfg.min_dispatch_delta = min_disp_ff;
      cfg.min_insn_delta     = min_insn_ff;
      cfg.cooldown_frames    = cooldown_ff;
      cfg.backoff_limit      = limit_ff;
      cfg.seed_signature     = seed_ff;
      // seed loading looks at the seed held before this write
      cfg.enable_set         = wr_en && (idx == REG_TRIGGER_ENABLE) && csr_pwdata[0];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ptb_core.sv =====
// Trigger state and the combinational decision for one frame event.
`default_nettype none

module ptb_core (
   input  wire                          clock,
   input  wire                          reset,
   input  ptb_pkg::ptb_cfg_type         cfg,
   input  wire                          fire,
   input  ptb_pkg::ptb_item_type        item,
   output ptb_pkg::ptb_result_type      result
);
   import ptb_pkg::*;

   logic        writing_ff,   writing_in;
   logic [63:0] last_frame_ff, last_frame_in;
   logic [63:0] last_disp_ff,  last_disp_in;
   logic [63:0] last_insn_ff,  last_insn_in;
   logic [63:0] disp_delta_ff, disp_delta_in;
   logic [63:0] insn_delta_ff, insn_delta_in;
   logic [63:0] next_frame_ff, next_frame_in;
   logic [63:0] req_sig_ff,    req_sig_in;
   logic [16:0] req_count_ff,  req_count_in;
   logic        seeded_ff,     seeded_in;
   logic [7:0]  backoff_ff,    backoff_in;
   logic [31:0] futile_ff,     futile_in;
   logic [31:0] trigger_ff,    trigger_in;

   logic [63:0] since_check;
   logic [63:0] disp_diff;
   logic [63:0] insn_diff;
   logic        sample_ok;
   logic        pressure;
   logic        can_fire;
   logic        same_write;
   logic [7:0]  backoff_up;
   logic [23:0] wait_frames;
   logic        start_bit;
   logic        compile_bit;
   logic        futile_bit;

   assign since_check = item.frame_count - last_frame_ff;
   assign disp_diff   = item.dispatch_total - last_disp_ff;
   assign insn_diff   = item.insn_total - last_insn_ff;
   assign sample_ok   = cfg.trigger_enable && item.capture_active && !writing_ff &&
                        (since_check >= {48'd0, cfg.check_interval});
   assign pressure    = (disp_diff >= {32'd0, cfg.min_dispatch_delta}) ||
                        (insn_diff >= {32'd0, cfg.min_insn_delta});
   assign can_fire    = pressure && !item.loading && !item.provider_busy &&
                        (item.frame_count >= next_frame_ff);
   assign same_write  = (item.manifest_signature == req_sig_ff) &&
                        (seeded_ff || ({1'b0, item.registered_count} == req_count_ff));
   // backoff is a power of two no larger than 128, so the double never drops a bit
   assign backoff_up  = (backoff_ff < {1'b0, cfg.backoff_limit}) ?
                        {backoff_ff[6:0], 1'b0} : backoff_ff;
   assign wait_frames = cfg.cooldown_frames * backoff_up;

   always_comb begin
      writing_in    = writing_ff;
      last_frame_in = last_frame_ff;
      last_disp_in  = last_disp_ff;
      last_insn_in  = last_insn_ff;
      disp_delta_in = disp_delta_ff;
      insn_delta_in = insn_delta_ff;
      next_frame_in = next_frame_ff;
      req_sig_in    = req_sig_ff;
      req_count_in  = req_count_ff;
      seeded_in     = seeded_ff;
      backoff_in    = backoff_ff;
      futile_in     = futile_ff;
      trigger_in    = trigger_ff;
      start_bit     = 1'b0;
      compile_bit   = 1'b0;
      futile_bit    = 1'b0;

      if (fire) begin
         case (item.op)
            OP_FINISH: begin
               if (writing_ff) begin
                  writing_in = 1'b0;
                  // a failed write only clears the busy flag
                  if (item.manifest_signature != 64'd0) begin
                     req_count_in = {1'b0, item.registered_count};
                     seeded_in    = 1'b0;
                     if (same_write) begin
                        futile_in     = futile_ff + 32'd1;
                        backoff_in    = backoff_up;
                        next_frame_in = item.frame_count + {40'd0, wait_frames};
                        futile_bit    = 1'b1;
                     end else begin
                        backoff_in  = 8'd1;
                        req_sig_in  = item.manifest_signature;
                        trigger_in  = trigger_ff + 32'd1;
                        compile_bit = 1'b1;
                     end
                  end
               end
            end
            default: begin
               if (sample_ok) begin
                  last_frame_in = item.frame_count;
                  last_disp_in  = item.dispatch_total;
                  last_insn_in  = item.insn_total;
                  disp_delta_in = disp_diff;
                  insn_delta_in = insn_diff;
                  if (can_fire) begin
                     next_frame_in = item.frame_count + {48'd0, cfg.cooldown_frames};
                     writing_in    = 1'b1;
                     start_bit     = 1'b1;
                  end
               end
            end
         endcase
      end else if (cfg.enable_set && (req_sig_ff == 64'd0) &&
                   (cfg.seed_signature != 64'd0)) begin
         req_sig_in = cfg.seed_signature;
         seeded_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         writing_ff    <= 1'b0;
         last_frame_ff <= 64'd0;
         last_disp_ff  <= 64'd0;
         last_insn_ff  <= 64'd0;
         disp_delta_ff <= 64'd0;
         insn_delta_ff <= 64'd0;
         next_frame_ff <= 64'd0;
         req_sig_ff    <= 64'd0;
         req_count_ff  <= COUNT_NONE;
         seeded_ff     <= 1'b0;
         backoff_ff    <= 8'd1;
         futile_ff     <= 32'd0;
         trigger_ff    <= 32'd0;
      end else begin
         writing_ff    <= writing_in;
         last_frame_ff <= last_frame_in;
         last_disp_ff  <= last_disp_in;
         last_insn_ff  <= last_insn_in;
         disp_delta_ff <= disp_delta_in;
         insn_delta_ff <= insn_delta_in;
         next_frame_ff <= next_frame_in;
         req_sig_ff    <= req_sig_in;
         req_count_ff  <= req_count_in;
         seeded_ff     <= seeded_in;
         backoff_ff    <= backoff_in;
         futile_ff     <= futile_in;
         trigger_ff    <= trigger_in;
      end
   end

   always_comb begin
      result.start_capture   = start_bit;
      result.request_compile = compile_bit;
      result.futile_skip     = futile_bit;
      result.backoff_now     = backoff_in;
      result.trigger_total   = trigger_in;
      result.futile_total    = futile_in;
      result.dispatch_delta  = disp_delta_in;
      result.insn_delta      = insn_delta_in;
   end

endmodule

`default_nettype wire
